// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL files, used by the controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/rxq_pkg.sv =====
// Package: types, constants and command/status structs of the range xor tree
package rxq_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int COUNT_W          = 11;
    localparam int IDX_W            = 10;
    localparam int DATA_W           = 32;
    localparam int IN_TDATA_W       = 56;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_QUERY  = 2'd2
    } t_opcode;

    // Which index a tree walk starts from
    typedef enum logic [2:0] {
        PT_A   = 3'd0,
        PT_AM1 = 3'd1,
        PT_A1  = 3'd2,
        PT_BC  = 3'd3,
        PT_BC1 = 3'd4
    } t_point;

    typedef struct packed {
        logic   clr_start;
        logic   clr_step;
        logic   accept;
        logic   walk_start;
        logic   walk_upd;
        t_point pt;
        logic   ram_rd;
        logic   walk_step;
        logic   delta_load;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       clr_last;
        logic       a_ge_n;
        logic       range_empty;
        logic       a_zero;
        logic       a1_in;
        logic       bc1_in;
        logic       walk_last;
        logic       out_full;
    } t_stat;

endpackage

// ===== hdl/rxq_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module rxq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/rxq_datapath.sv =====
// Datapath: item registers, parity Fenwick trees in RAM, walk unit, result register
module rxq_datapath #(
    parameter int MAX_ELEMENTS = rxq_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rxq_pkg::t_cmd                  i_cmd,
    output rxq_pkg::t_stat                 o_stat,
    input  logic [rxq_pkg::IN_TDATA_W-1:0] i_in_data,
    input  logic [1:0]                     i_in_user,
    input  logic                           i_cfg_valid,
    input  logic [rxq_pkg::COUNT_W-1:0]    i_cfg_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [rxq_pkg::DATA_W-1:0]     o_out_data
);
    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int KW = $clog2(MAX_ELEMENTS + 1) + 1;
    localparam int DW = rxq_pkg::DATA_W;
    localparam int IW = rxq_pkg::IDX_W;
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_ELEMENTS - 1);

    logic [rxq_pkg::COUNT_W-1:0] r_count;
    logic [1:0]    r_op;
    logic [IW-1:0] r_a, r_b;
    logic [DW-1:0] r_mask, r_acc, r_out_data;
    logic          r_out_valid;
    logic [KW-1:0] r_k;
    logic          r_cls, r_upd;
    logic [AW-1:0] r_clr;

    logic [KW-1:0] n_cnt;
    logic [31:0]   n32, a32, b32, bc32, p32;
    logic [KW-1:0] lowbit, k_up, k_dn, km1;
    logic [2*DW-1:0] rdata, wdata, upd_mask;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [DW-1:0]   rd_half;

    // Active element count, clamped to 1..MAX_ELEMENTS
    always_comb begin
        if (r_count == '0) begin
            n_cnt = KW'(1);
        end else if (32'(r_count) > 32'(MAX_ELEMENTS)) begin
            n_cnt = KW'(MAX_ELEMENTS);
        end else begin
            n_cnt = KW'(r_count);
        end
    end

    // Range clipping and flags
    assign n32  = 32'(n_cnt);
    assign a32  = 32'(r_a);
    assign b32  = 32'(r_b);
    assign bc32 = (b32 > n32 - 32'd1) ? n32 - 32'd1 : b32;

    assign o_stat.op          = r_op;
    assign o_stat.clr_last    = (r_clr == CLR_LAST);
    assign o_stat.a_ge_n      = (a32 >= n32);
    assign o_stat.range_empty = (a32 > b32) || (a32 >= n32);
    assign o_stat.a_zero      = (r_a == '0);
    assign o_stat.a1_in       = (a32 + 32'd1 < n32);
    assign o_stat.bc1_in      = (bc32 + 32'd1 < n32);
    assign o_stat.out_full    = r_out_valid;

    // Start index of a walk
    always_comb begin
        case (i_cmd.pt)
            rxq_pkg::PT_A:   p32 = a32;
            rxq_pkg::PT_AM1: p32 = a32 - 32'd1;
            rxq_pkg::PT_A1:  p32 = a32 + 32'd1;
            rxq_pkg::PT_BC:  p32 = bc32;
            rxq_pkg::PT_BC1: p32 = bc32 + 32'd1;
            default:         p32 = a32;
        endcase
    end

    // Fenwick step: lowest set bit up or down
    assign lowbit = r_k & (~r_k + KW'(1));
    assign k_up   = r_k + lowbit;
    assign k_dn   = r_k - lowbit;
    assign km1    = r_k - KW'(1);
    assign o_stat.walk_last = r_upd ? (k_up > n_cnt) : (k_dn == '0);

    // Upper half holds the odd-index tree, lower half the even-index tree
    assign rd_half  = r_cls ? rdata[2*DW-1:DW] : rdata[DW-1:0];
    assign upd_mask = r_cls ? {r_mask, {DW{1'b0}}} : {{DW{1'b0}}, r_mask};

    always_comb begin
        we    = 1'b0;
        waddr = km1[AW-1:0];
        wdata = rdata ^ upd_mask;
        if (i_cmd.clr_step) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = '0;
        end else if (i_cmd.walk_step && r_upd) begin
            we = 1'b1;
        end
    end

    rxq_ram #(
        .WIDTH(2 * DW),
        .DEPTH(MAX_ELEMENTS)
    ) u_tree (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (i_cmd.ram_rd),
        .i_raddr(km1[AW-1:0]),
        .o_rdata(rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= rxq_pkg::COUNT_RESET;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
            if (i_cmd.clr_start) begin
                r_clr <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_in_user;
            r_a    <= i_in_data[IW-1:0];
            r_b    <= i_in_data[2*IW-1:IW];
            r_mask <= i_in_data[2*IW+DW-1:2*IW];
            r_acc  <= '0;
        end
        if (i_cmd.delta_load) begin
            r_mask <= r_mask ^ r_acc;
        end
        if (i_cmd.walk_start) begin
            r_k   <= KW'(p32 + 32'd1);
            r_cls <= p32[0];
            r_upd <= i_cmd.walk_upd;
        end
        if (i_cmd.walk_step) begin
            r_k <= r_upd ? k_up : k_dn;
            if (!r_upd) begin
                r_acc <= r_acc ^ rd_half;
            end
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_acc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule

// ===== hdl/rxq_ctrl.sv =====
// Controller: sequences clearing, tree walks and result hand-off
`include "assert_macros.svh"
module rxq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_cfg_valid,
    input  rxq_pkg::t_stat i_stat,
    output rxq_pkg::t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_NEXT, S_RD, S_DAT, S_OUT
    } t_state;

    t_state        r_state, n_state;
    logic [2:0]    r_phase, n_phase;
    rxq_pkg::t_cmd cmd;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        cmd     = '0;
        cmd.pt  = rxq_pkg::PT_A;
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_NEXT;
                    n_phase    = '0;
                end
            end
            S_NEXT: begin
                n_phase = r_phase + 3'd1;
                case (i_stat.op)
                    rxq_pkg::OP_QUERY: begin
                        if (i_stat.range_empty) begin
                            n_state = S_OUT;
                        end else if (r_phase == 3'd0) begin
                            cmd.walk_start = 1'b1;
                            cmd.pt         = rxq_pkg::PT_BC;
                        end else if (r_phase == 3'd1 && !i_stat.a_zero) begin
                            cmd.walk_start = 1'b1;
                            cmd.pt         = rxq_pkg::PT_AM1;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                    rxq_pkg::OP_UPDATE: begin
                        if (i_stat.range_empty) begin
                            n_state = S_IDLE;
                        end else if (r_phase == 3'd0) begin
                            cmd.walk_start = 1'b1;
                            cmd.walk_upd   = 1'b1;
                            cmd.pt         = rxq_pkg::PT_A;
                        end else if (r_phase == 3'd1 && i_stat.bc1_in) begin
                            cmd.walk_start = 1'b1;
                            cmd.walk_upd   = 1'b1;
                            cmd.pt         = rxq_pkg::PT_BC1;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    rxq_pkg::OP_LOAD: begin
                        // read old value as prefix difference, then apply the delta
                        if (i_stat.a_ge_n) begin
                            n_state = S_IDLE;
                        end else if (r_phase == 3'd0) begin
                            cmd.walk_start = 1'b1;
                            cmd.pt         = rxq_pkg::PT_A;
                        end else if (r_phase == 3'd1) begin
                            if (!i_stat.a_zero) begin
                                cmd.walk_start = 1'b1;
                                cmd.pt         = rxq_pkg::PT_AM1;
                            end
                        end else if (r_phase == 3'd2) begin
                            cmd.delta_load = 1'b1;
                        end else if (r_phase == 3'd3) begin
                            cmd.walk_start = 1'b1;
                            cmd.walk_upd   = 1'b1;
                            cmd.pt         = rxq_pkg::PT_A;
                        end else if (r_phase == 3'd4 && i_stat.a1_in) begin
                            cmd.walk_start = 1'b1;
                            cmd.walk_upd   = 1'b1;
                            cmd.pt         = rxq_pkg::PT_A1;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
                if (cmd.walk_start) n_state = S_RD;
            end
            S_RD: begin
                cmd.ram_rd = 1'b1;
                n_state    = S_DAT;
            end
            S_DAT: begin
                cmd.walk_step = 1'b1;
                n_state       = i_stat.walk_last ? S_NEXT : S_RD;
            end
            S_OUT: begin
                if (!i_stat.out_full) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
        // a count write restarts the clearing sweep
        if (i_cfg_valid) begin
            cmd.clr_start = 1'b1;
            n_state       = S_CLEAR;
        end
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    `ASSERT_CLK(a_cfg_clears, i_clk, i_rst_n, i_cfg_valid |=> r_state == S_CLEAR, "cfg write did not start clear")
    `ASSERT_CLK(a_accept_plans, i_clk, i_rst_n, (cmd.accept && !i_cfg_valid) |=> r_state == S_NEXT, "accepted item not planned")
    `ASSERT_NEVER(a_out_overrun, i_clk, i_rst_n, cmd.out_load && i_stat.out_full, "result register overwritten")
endmodule

// ===== hdl/range_xor_update_query_tree.sv =====
// Top level: range xor update / query block over a parity Fenwick tree pair
//
//  channel   | direction | handshake                    | payload
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: low, high, value; tuser: op
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: xor_result
//  cfg       | in        | i_cfg_valid/o_cfg_ready      | i_cfg_data: element_count
//
// A tree walk visits up to log2(MAX_ELEMENTS)+1 nodes, each with a RAM read state (S_RD)
// and a step state (S_DAT) that also writes back for updates. Updates and queries run up
// to two walks, loads up to four walks and a delta step.
// After reset and after every count write a clearing pass over all MAX_ELEMENTS RAM words
// runs (1024 by default); no item is taken meanwhile.
// A result waits in an output register; the next item is taken while it waits, and a
// later query stalls in its output step until that register drains.
module range_xor_update_query_tree #(
    parameter int MAX_ELEMENTS = rxq_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [9:0] range_low, [19:10] range_high, [51:20] operand_value, [55:52] zero
    input  logic [rxq_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] xor_result
    output logic [rxq_pkg::DATA_W-1:0]     m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rxq_pkg::COUNT_W-1:0]    i_cfg_data
);
    rxq_pkg::t_cmd  cmd;
    rxq_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    rxq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_cfg_valid(i_cfg_valid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rxq_datapath #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in_data  (s_axis_tdata),
        .i_in_user  (s_axis_tuser),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_out_data (m_axis_tdata)
    );
endmodule

// ===== test/range_xor_update_query_tree_tb.sv =====
// Testbench for the range xor update / query tree: directed and random items checked
// against an element-array predictor.
module range_xor_update_query_tree_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_TDATA_W       = rxq_pkg::IN_TDATA_W;
    localparam int DATA_W           = rxq_pkg::DATA_W;
    localparam int COUNT_W          = rxq_pkg::COUNT_W;
    localparam int IDX_W            = rxq_pkg::IDX_W;
    localparam int MAX_ELEMENTS_DEF = rxq_pkg::MAX_ELEMENTS_DEF;
    localparam logic [1:0] OP_IGNORED = 2'd3;
    // Cycles allowed after the last result before the block is taken as idle
    localparam int SETTLE_CYCLES = 120;
    // Covers the clearing pass after a count write plus the slowest item
    localparam int WATCHDOG_LIMIT = 8000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [COUNT_W-1:0]    i_cfg_data;

    // Predictor state: plain element array and the effective count
    logic [DATA_W-1:0]     element_val[MAX_ELEMENTS_DEF];
    int unsigned           live_count;
    logic [DATA_W-1:0]     expected_xor[$];
    int                    fail_count;
    int                    idle_cycles;
    int                    result_stall;

    range_xor_update_query_tree dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Apply one item to the element array; returns 1 with the xor for a query
    function automatic bit apply_item(input logic [1:0] op, input int unsigned lo,
                                      input int unsigned hi, input logic [DATA_W-1:0] val,
                                      output logic [DATA_W-1:0] range_xor);
        int unsigned top;
        range_xor = '0;
        top = (hi < live_count) ? hi : live_count - 1;
        case (op)
            rxq_pkg::OP_LOAD: begin
                if (lo < live_count) element_val[lo] = val;
                return 1'b0;
            end
            rxq_pkg::OP_UPDATE: begin
                if (lo <= hi)
                    for (int unsigned i = lo; i <= top; i++) element_val[i] ^= val;
                return 1'b0;
            end
            rxq_pkg::OP_QUERY: begin
                if (lo <= hi)
                    for (int unsigned i = lo; i <= top; i++) range_xor ^= element_val[i];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Send one item after a random gap; predicts it once accepted
    task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] lo,
                             input logic [IDX_W-1:0] hi, input logic [DATA_W-1:0] val);
        int gap;
        logic [DATA_W-1:0] r;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, val, hi, lo};
        do @(posedge i_clk); while (!s_axis_tready);
        if (apply_item(op, lo, hi, val, r)) expected_xor = {expected_xor, r};
    endtask

    // Drain results, settle, then write the count register
    task automatic write_count(input logic [COUNT_W-1:0] count);
        s_axis_tvalid <= 1'b0;
        wait (expected_xor.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        live_count = (count == 0) ? 1 : (count > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : count;
        foreach (element_val[i]) element_val[i] = '0;
    endtask

    // Index mostly inside the live range, sometimes anywhere
    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(0, 4) == 0) return IDX_W'($urandom_range(0, MAX_ELEMENTS_DEF - 1));
        return IDX_W'($urandom_range(0, live_count - 1));
    endfunction

    task automatic test_directed();
        send_item(rxq_pkg::OP_QUERY, 10'd0, 10'd1023, 32'h0);
        send_item(rxq_pkg::OP_LOAD, 10'd0, 10'd0, 32'hFFFF_FFFF);
        send_item(rxq_pkg::OP_LOAD, 10'd1023, 10'd0, 32'h8000_0001);
        send_item(rxq_pkg::OP_LOAD, 10'd512, 10'h3FF, 32'h1234_5678);
        send_item(rxq_pkg::OP_QUERY, 10'd0, 10'd1023, 32'hFFFF_FFFF);
        send_item(rxq_pkg::OP_UPDATE, 10'd0, 10'd1023, 32'hFFFF_FFFF);
        send_item(rxq_pkg::OP_QUERY, 10'd0, 10'd1023, 32'h0);
        send_item(rxq_pkg::OP_UPDATE, 10'd3, 10'd6, 32'hA5A5_A5A5);
        send_item(rxq_pkg::OP_QUERY, 10'd2, 10'd5, 32'h0);
        send_item(rxq_pkg::OP_QUERY, 10'd1023, 10'd1023, 32'h0);
        // empty range: low above high
        send_item(rxq_pkg::OP_UPDATE, 10'd9, 10'd8, 32'hDEAD_BEEF);
        send_item(rxq_pkg::OP_QUERY, 10'd9, 10'd8, 32'h0);
        send_item(rxq_pkg::OP_QUERY, 10'd1023, 10'd0, 32'h0);
        // unknown opcode gives no result
        send_item(OP_IGNORED, 10'd0, 10'd1023, 32'hFFFF_FFFF);
        send_item(rxq_pkg::OP_QUERY, 10'd0, 10'd9, 32'h0);
        // small count: loads and ranges beyond it
        write_count(11'd4);
        send_item(rxq_pkg::OP_LOAD, 10'd3, 10'd0, 32'h0000_00F0);
        send_item(rxq_pkg::OP_LOAD, 10'd5, 10'd0, 32'h0000_000F);
        send_item(rxq_pkg::OP_UPDATE, 10'd2, 10'd1023, 32'h0101_0101);
        send_item(rxq_pkg::OP_QUERY, 10'd0, 10'd1023, 32'h0);
        send_item(rxq_pkg::OP_UPDATE, 10'd8, 10'd20, 32'hFFFF_0000);
        send_item(rxq_pkg::OP_QUERY, 10'd4, 10'd1023, 32'h0);
        send_item(rxq_pkg::OP_QUERY, 10'd3, 10'd3, 32'h0);
    endtask

    task automatic test_random(input int n_items);
        logic [1:0] op;
        logic [IDX_W-1:0] lo, hi, t;
        int sel;
        for (int k = 0; k < n_items; k++) begin
            sel = $urandom_range(0, 19);
            op = (sel < 6) ? rxq_pkg::OP_LOAD : (sel < 12) ? rxq_pkg::OP_UPDATE :
                 (sel < 19) ? rxq_pkg::OP_QUERY : OP_IGNORED;
            lo = pick_index();
            hi = pick_index();
            // mostly ordered ranges, a few empty ones
            if (lo > hi && $urandom_range(0, 5) != 0) begin
                t = lo; lo = hi; hi = t;
            end
            send_item(op, lo, hi, $urandom());
        end
    endtask

    task automatic test_counts();
        write_count(11'd0);
        test_random(40);
        write_count(11'd1);
        test_random(40);
        write_count(11'd37);
        test_random(150);
        write_count(11'h7FF);
        test_random(150);
        write_count(11'd2);
        test_random(40);
        write_count(11'd1024);
        test_random(100);
    endtask

    // Result side: random stalls, each result checked against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            result_stall  <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_xor.size() == 0) begin
                    $error("unexpected result xor_result=%h", m_axis_tdata);
                    fail_count++;
                end else begin
                    if (m_axis_tdata !== expected_xor[0]) begin
                        $error("xor_result expected %h actual %h", expected_xor[0],
                               m_axis_tdata);
                        fail_count++;
                    end
                    void'(expected_xor.pop_front());
                end
                result_stall <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
                m_axis_tready <= 1'b0;
            end else if (result_stall > 0) begin
                result_stall  <= result_stall - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = rxq_pkg::OP_LOAD;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        fail_count    = 0;
        live_count    = MAX_ELEMENTS_DEF;
        foreach (element_val[i]) element_val[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        write_count(11'd1024);
        test_random(200);
        test_counts();

        s_axis_tvalid <= 1'b0;
        wait (expected_xor.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
